[design/cylindrical_grid_cell_lookup_defines.svh]
// Assertion macros used by the checker file.
`ifndef CYLINDRICAL_GRID_CELL_LOOKUP_DEFINES_SVH
`define CYLINDRICAL_GRID_CELL_LOOKUP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CGCL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CGCL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/cgcl_pkg.sv]
package cgcl_pkg;

    localparam int AXIS_DEPTH   = 64;
    localparam int CELL_DEPTH   = 4096;
    localparam int CORDIC_STEPS = 32;

    localparam int AXIS_AW = $clog2(AXIS_DEPTH);
    localparam int CELL_AW = $clog2(CELL_DEPTH);
    localparam int CNT_W   = AXIS_AW + 1;
    localparam int FLAT_W  = (3 * AXIS_AW > 12) ? 3 * AXIS_AW : 12;
    localparam int STEP_W  = 6;

    localparam logic [31:0] PHI_HALF_PI = 32'd843314857;
    localparam logic [31:0] PHI_PI      = 32'd1686629713;
    localparam logic [31:0] PHI_TWO_PI  = 32'd3373259426;

    // Item commands
    localparam logic [2:0] CMD_QUERY   = 3'd0;
    localparam logic [2:0] CMD_RADIAL  = 3'd1;
    localparam logic [2:0] CMD_HEIGHT  = 3'd2;
    localparam logic [2:0] CMD_AZIMUTH = 3'd3;
    localparam logic [2:0] CMD_CELL    = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_RADIAL_CELLS  = 3'd0;
    localparam logic [2:0] REG_HEIGHT_CELLS  = 3'd1;
    localparam logic [2:0] REG_AZIMUTH_CELLS = 3'd2;
    localparam logic [2:0] REG_DEFAULT_MODE  = 3'd3;
    localparam logic [2:0] REG_WIND_TEMP     = 3'd4;

    // arctan(2^-i) in Q3.29
    function automatic logic [30:0] atan_at(input logic [STEP_W-1:0] i);
        logic [30:0] v;
        case (i)
            6'd0:    v = 31'd421657428;
            6'd1:    v = 31'd248918915;
            6'd2:    v = 31'd131521918;
            6'd3:    v = 31'd66762579;
            6'd4:    v = 31'd33510843;
            6'd5:    v = 31'd16771758;
            6'd6:    v = 31'd8387925;
            6'd7:    v = 31'd4194219;
            6'd8:    v = 31'd2097141;
            6'd9:    v = 31'd1048575;
            6'd10:   v = 31'd524288;
            6'd11:   v = 31'd262144;
            6'd12:   v = 31'd131072;
            6'd13:   v = 31'd65536;
            6'd14:   v = 31'd32768;
            6'd15:   v = 31'd16384;
            6'd16:   v = 31'd8192;
            6'd17:   v = 31'd4096;
            6'd18:   v = 31'd2048;
            6'd19:   v = 31'd1024;
            6'd20:   v = 31'd512;
            6'd21:   v = 31'd256;
            6'd22:   v = 31'd128;
            6'd23:   v = 31'd64;
            6'd24:   v = 31'd32;
            6'd25:   v = 31'd16;
            6'd26:   v = 31'd8;
            6'd27:   v = 31'd4;
            6'd28:   v = 31'd2;
            6'd29:   v = 31'd1;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

    // Zero acts as one, anything above the table depth as the depth.
    function automatic logic [CNT_W-1:0] clamp_count(input logic [6:0] n);
        logic [CNT_W-1:0] r;
        if (n == 7'd0)
            r = CNT_W'(1);
        else if (int'(n) > AXIS_DEPTH)
            r = CNT_W'(AXIS_DEPTH);
        else
            r = CNT_W'(n);
        return r;
    endfunction

endpackage

[design/cgcl_cordic.sv]
module cgcl_cordic
    import cgcl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] x_mag,
    input  logic [47:0] y_mag,
    input  logic        x_neg,
    input  logic        y_neg,
    output logic        done,
    output logic [31:0] phi
);

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_NORM = 4'b0010,
        C_ROT  = 4'b0100,
        C_DONE = 4'b1000
    } cstate_t;

    cstate_t                   state_reg, state_next;
    logic [47:0]               ax_reg, ax_next, ay_reg, ay_next;
    logic signed [50:0]        cx_reg, cx_next, cy_reg, cy_next;
    logic signed [32:0]        a_reg, a_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic                      xn_reg, xn_next, yn_reg, yn_next;
    logic [47:0]               mor;
    logic signed [50:0]        dx, dy;
    logic signed [32:0]        atan_s;
    logic [31:0]               ac;
    logic [32:0]               t;

    assign mor    = ax_reg | ay_reg;
    assign dx     = cy_reg >>> step_reg;
    assign dy     = cx_reg >>> step_reg;
    assign atan_s = $signed({2'b00, atan_at(step_reg)});

    always_comb
    begin
        state_next = state_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        a_next     = a_reg;
        step_next  = step_reg;
        xn_next    = xn_reg;
        yn_next    = yn_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    ax_next = x_mag;
                    ay_next = y_mag;
                    xn_next = x_neg;
                    yn_next = y_neg;
                    a_next  = '0;
                    // origin: angle stays zero
                    state_next = (x_mag == 48'd0 && y_mag == 48'd0) ? C_DONE : C_NORM;
                end
            end
            C_NORM:
            begin
                if (mor[47:46] != 2'b00)
                begin
                    cx_next    = $signed({3'b000, ax_reg});
                    cy_next    = $signed({3'b000, ay_reg});
                    step_next  = '0;
                    state_next = C_ROT;
                end
                else if (mor[45:38] == 8'd0)
                begin
                    ax_next = ax_reg << 8;
                    ay_next = ay_reg << 8;
                end
                else
                begin
                    ax_next = ax_reg << 1;
                    ay_next = ay_reg << 1;
                end
            end
            C_ROT:
            begin
                if (!cy_reg[50])
                begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    a_next  = a_reg + atan_s;
                end
                else
                begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    a_next  = a_reg - atan_s;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                    state_next = C_DONE;
            end
            C_DONE:
            begin
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= C_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        a_reg    <= a_next;
        step_reg <= step_next;
        xn_reg   <= xn_next;
        yn_reg   <= yn_next;
    end

    // Clamp to the first quadrant, then restore the quadrant.
    always_comb
    begin
        if (a_reg[32])
            ac = 32'd0;
        else if (a_reg > $signed({1'b0, PHI_HALF_PI}))
            ac = PHI_HALF_PI;
        else
            ac = a_reg[31:0];
        if (xn_reg)
            t = yn_reg ? ({1'b0, PHI_PI} + {1'b0, ac}) : ({1'b0, PHI_PI} - {1'b0, ac});
        else
            t = yn_reg ? ({1'b0, PHI_TWO_PI} - {1'b0, ac}) : {1'b0, ac};
        if (t >= {1'b0, PHI_TWO_PI})
            t = t - {1'b0, PHI_TWO_PI};
    end

    assign phi  = t[31:0];
    assign done = (state_reg == C_DONE);

endmodule

[design/cgcl_root.sv]
module cgcl_root
    import cgcl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [95:0] sum_sq,
    input  logic [28:0] wind,
    output logic        done,
    output logic [47:0] radius,
    output logic [31:0] wind_hot
);

    typedef enum logic [2:0] {
        R_IDLE = 3'b001,
        R_RUN  = 3'b010,
        R_DONE = 3'b100
    } rstate_t;

    rstate_t           state_reg, state_next;
    logic [95:0]       s_reg, s_next;
    logic [49:0]       rem_reg, rem_next;
    logic [47:0]       root_reg, root_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [63:0]       tenth_reg, tenth_next;
    logic [31:0]       wind5;
    logic [51:0]       rs, trial;

    assign rs    = {rem_reg, s_reg[95:94]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign wind5 = {3'b000, wind} + 32'd5;

    always_comb
    begin
        state_next = state_reg;
        s_next     = s_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        step_next  = step_reg;
        tenth_next = tenth_reg;
        case (state_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    s_next    = sum_sq;
                    rem_next  = '0;
                    root_next = '0;
                    step_next = '0;
                    // (wind * 11 + 5) / 10 = wind + (wind + 5) / 10; divide by ten
                    // with the reciprocal 0xCCCCCCCD / 2^35, exact below 2^32
                    tenth_next = wind5 * 32'hCCCCCCCD;
                    state_next = R_RUN;
                end
            end
            R_RUN:
            begin
                if (rs >= trial)
                begin
                    rem_next  = 50'(rs - trial);
                    root_next = {root_reg[46:0], 1'b1};
                end
                else
                begin
                    rem_next  = rs[49:0];
                    root_next = {root_reg[46:0], 1'b0};
                end
                s_next = s_reg << 2;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(47))
                    state_next = R_DONE;
            end
            R_DONE:
            begin
                state_next = R_IDLE;
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= R_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        s_reg     <= s_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        step_reg  <= step_next;
        tenth_reg <= tenth_next;
    end

    assign done     = (state_reg == R_DONE);
    assign radius   = root_reg;
    assign wind_hot = {3'b000, wind} + {3'b000, tenth_reg[63:35]};

endmodule

[design/cgcl_store.sv]
module cgcl_store
    import cgcl_pkg::*;
(
    input  logic               clk,
    input  logic               we,
    input  logic [CELL_AW-1:0] waddr,
    input  logic [63:0]        wdensity,
    input  logic [31:0]        welectron,
    input  logic [31:0]        wradiation,
    input  logic [CELL_AW-1:0] raddr,
    output logic [63:0]        rdensity,
    output logic [31:0]        relectron,
    output logic [31:0]        rradiation
);

    logic [127:0] mem [CELL_DEPTH];
    logic [127:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= {wdensity, welectron, wradiation};
        rd_reg <= mem[raddr];
    end

    assign rdensity   = rd_reg[127:64];
    assign relectron  = rd_reg[63:32];
    assign rradiation = rd_reg[31:0];

endmodule

[design/cylindrical_grid_cell_lookup.sv]
// Cylindrical grid cell lookup.
// Query channel: query_valid/query_stall with cmd and the payload ports. A query
// item (cmd 0) carries x, y, z; the block finds the cell along radius, height
// and azimuth and returns one item on the result channel. Edge and cell write
// items (cmd 1..4) update the tables in the cycle they are accepted and return
// nothing; unknown commands are dropped.
// Config port: cfg_write/cfg_index/cfg_data; the user writes it only while idle,
// which the block itself does not enforce. A query runs the squares on one
// shared 24x24 multiplier, the bit-per-cycle square root, normalization plus
// 32 CORDIC steps and a done state for the azimuth (the origin skips the
// normalization and the steps), the linear boundary search (one table entry
// per cycle, all three axes together), the flat index, the cell store read
// and the result load. Query_stall stays high for all of that, so no item is
// taken until the query is done; write items leave the block idle.
// Reset: cell counts go to 1, default-temperature mode on, wind temperature 0.
// Boundary tables and the cell store are not cleared; read only what was
// written. A stalled result holds on the result ports; a finished query
// waits in its last step until the result register is free.
module cylindrical_grid_cell_lookup
    import cgcl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        query_valid,
    output logic        query_stall,
    input  logic [2:0]  cmd,
    input  logic [11:0] entry_index,
    input  logic [47:0] pos_x,
    input  logic [47:0] pos_y,
    input  logic [47:0] pos_z,
    input  logic        want_electron_temp,
    input  logic [47:0] edge_value,
    input  logic [63:0] density_word,
    input  logic [31:0] electron_temp_in,
    input  logic [31:0] radiation_temp_in,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [63:0] density,
    output logic [31:0] temperature,
    output logic [11:0] cell_index,
    output logic        in_store,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [28:0] cfg_data
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL   = 9'b000000010,
        S_ROOT  = 9'b000000100,
        S_ANG   = 9'b000001000,
        S_SRCH  = 9'b000010000,
        S_FLAT1 = 9'b000100000,
        S_FLAT2 = 9'b001000000,
        S_READ  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [6:0]  nr_reg, nz_reg, np_reg;
    logic        mode_reg;
    logic [28:0] wind_reg;
    logic [CNT_W-1:0] nr_eff, nz_eff, np_eff;

    // query operands
    logic [47:0] xm_reg, ym_reg, z_reg;
    logic        xn_reg, yn_reg, want_reg;
    logic [47:0] xm_in, ym_in;

    // squares
    logic [2:0]  mstep_reg, mstep_next;
    logic [47:0] prod_reg, prod_next;
    logic [95:0] acc_reg, acc_next, acc_term;
    logic [23:0] mul_a, mul_b;

    // search
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [AXIS_AW-1:0] ir_reg, ir_next, iz_reg, iz_next, ip_reg, ip_next;
    logic               dr_reg, dr_next, dz_reg, dz_next, dp_reg, dp_next;
    logic [AXIS_AW-1:0] srch_addr;
    logic [47:0]        radial_mem [AXIS_DEPTH];
    logic [47:0]        height_mem [AXIS_DEPTH];
    logic [31:0]        azimuth_mem [AXIS_DEPTH];
    logic [47:0]        rd_radial, rd_height;
    logic [31:0]        rd_azimuth;
    logic               cond_r, cond_z, cond_p, cnt_in_r, cnt_in_z, cnt_in_p;

    // flat index
    logic [2*AXIS_AW-1:0] t_reg, t_next;
    logic [FLAT_W-1:0]    flat_reg, flat_next;
    logic                 flat_inside;

    // shared units
    logic        root_start, root_done, cordic_done;
    logic [47:0] radius;
    logic [31:0] wind_hot, phi;

    // cell store
    logic        cell_we;
    logic [63:0] rd_density;
    logic [31:0] rd_electron, rd_radiation;

    // result register
    logic        rv_reg;
    logic [63:0] density_reg;
    logic [31:0] temp_reg, temp_sel;
    logic [11:0] cidx_reg;
    logic        ins_reg;
    logic        out_load;

    logic query_accept, edge_ok;

    assign query_stall  = (state_reg != S_IDLE);
    assign query_accept = query_valid && !query_stall;
    assign edge_ok      = int'(entry_index) < AXIS_DEPTH;
    assign cell_we      = query_accept && cmd == CMD_CELL && int'(entry_index) < CELL_DEPTH;

    assign xm_in = pos_x[47] ? (~pos_x + 48'd1) : pos_x;
    assign ym_in = pos_y[47] ? (~pos_y + 48'd1) : pos_y;

    assign nr_eff = clamp_count(nr_reg);
    assign nz_eff = clamp_count(nz_reg);
    assign np_eff = clamp_count(np_reg);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nr_reg   <= 7'd1;
            nz_reg   <= 7'd1;
            np_reg   <= 7'd1;
            mode_reg <= 1'b1;
            wind_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_RADIAL_CELLS:  nr_reg   <= cfg_data[6:0];
                REG_HEIGHT_CELLS:  nz_reg   <= cfg_data[6:0];
                REG_AZIMUTH_CELLS: np_reg   <= cfg_data[6:0];
                REG_DEFAULT_MODE:  mode_reg <= cfg_data[0];
                REG_WIND_TEMP:     wind_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Boundary tables: one write port from the item channel, one read port
    // that follows the search counter.
    always_ff @(posedge clk)
    begin
        if (query_accept && edge_ok && cmd == CMD_RADIAL)
            radial_mem[entry_index[AXIS_AW-1:0]] <= edge_value;
        rd_radial <= radial_mem[srch_addr];
    end

    always_ff @(posedge clk)
    begin
        if (query_accept && edge_ok && cmd == CMD_HEIGHT)
            height_mem[entry_index[AXIS_AW-1:0]] <= edge_value;
        rd_height <= height_mem[srch_addr];
    end

    always_ff @(posedge clk)
    begin
        if (query_accept && edge_ok && cmd == CMD_AZIMUTH)
            azimuth_mem[entry_index[AXIS_AW-1:0]] <= edge_value[31:0];
        rd_azimuth <= azimuth_mem[srch_addr];
    end

    // Shared multiplier: x0*x0, x0*x1, x1*x1, then the same for y. The product
    // is registered and folded into the sum in the next cycle.
    always_comb
    begin
        case (mstep_reg)
            3'd0:    begin mul_a = xm_reg[23:0];  mul_b = xm_reg[23:0];  end
            3'd1:    begin mul_a = xm_reg[23:0];  mul_b = xm_reg[47:24]; end
            3'd2:    begin mul_a = xm_reg[47:24]; mul_b = xm_reg[47:24]; end
            3'd3:    begin mul_a = ym_reg[23:0];  mul_b = ym_reg[23:0];  end
            3'd4:    begin mul_a = ym_reg[23:0];  mul_b = ym_reg[47:24]; end
            3'd5:    begin mul_a = ym_reg[47:24]; mul_b = ym_reg[47:24]; end
            default: begin mul_a = '0;            mul_b = '0;            end
        endcase
        prod_next = mul_a * mul_b;
        // the cross term counts twice, hence the shift by 25
        case (mstep_reg)
            3'd1, 3'd4: acc_term = {48'd0, prod_reg};
            3'd2, 3'd5: acc_term = {48'd0, prod_reg} << 25;
            3'd3, 3'd6: acc_term = {48'd0, prod_reg} << 48;
            default:    acc_term = '0;
        endcase
    end

    // Search compares on the entry at cnt_reg.
    assign cond_r   = rd_radial[47] || (rd_radial <= radius);
    assign cond_z   = $signed(z_reg) >= $signed(rd_height);
    assign cond_p   = phi >= rd_azimuth;
    assign cnt_in_r = cnt_reg < nr_eff;
    assign cnt_in_z = cnt_reg < nz_eff;
    assign cnt_in_p = cnt_reg < np_eff;
    assign srch_addr = cnt_next[AXIS_AW-1:0];

    assign flat_inside = int'(flat_reg) < CELL_DEPTH;

    // Main sequencer
    always_comb
    begin
        state_next = state_reg;
        mstep_next = mstep_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        ir_next    = ir_reg;
        iz_next    = iz_reg;
        ip_next    = ip_reg;
        dr_next    = dr_reg;
        dz_next    = dz_reg;
        dp_next    = dp_reg;
        t_next     = t_reg;
        flat_next  = flat_reg;
        root_start = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (query_accept && cmd == CMD_QUERY)
                begin
                    mstep_next = '0;
                    acc_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                acc_next   = acc_reg + acc_term;
                mstep_next = mstep_reg + 1'b1;
                if (mstep_reg == 3'd6)
                begin
                    root_start = 1'b1;
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (root_done)
                    state_next = S_ANG;
            end
            S_ANG:
            begin
                if (cordic_done)
                begin
                    cnt_next   = CNT_W'(1);
                    ir_next    = '0;
                    iz_next    = '0;
                    ip_next    = '0;
                    dr_next    = 1'b0;
                    dz_next    = 1'b0;
                    dp_next    = 1'b0;
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (!dr_reg)
                begin
                    if (cnt_in_r && cond_r)
                        ir_next = cnt_reg[AXIS_AW-1:0];
                    else
                        dr_next = 1'b1;
                end
                if (!dz_reg)
                begin
                    if (cnt_in_z && cond_z)
                        iz_next = cnt_reg[AXIS_AW-1:0];
                    else
                        dz_next = 1'b1;
                end
                if (!dp_reg)
                begin
                    if (cnt_in_p && cond_p)
                        ip_next = cnt_reg[AXIS_AW-1:0];
                    else
                        dp_next = 1'b1;
                end
                cnt_next = cnt_reg + 1'b1;
                if ((dr_next && dz_next && dp_next) || cnt_reg == CNT_W'(AXIS_DEPTH - 1))
                    state_next = S_FLAT1;
            end
            S_FLAT1:
            begin
                t_next     = (2*AXIS_AW)'(ir_reg * nz_eff + iz_reg);
                state_next = S_FLAT2;
            end
            S_FLAT2:
            begin
                flat_next  = FLAT_W'(t_reg * np_eff + ip_reg);
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // wait here until the result register is free
                if (!rv_reg || !result_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                rv_reg <= 1'b1;
            else if (!result_stall)
                rv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_accept)
        begin
            xm_reg   <= xm_in;
            ym_reg   <= ym_in;
            xn_reg   <= pos_x[47];
            yn_reg   <= pos_y[47];
            z_reg    <= pos_z;
            want_reg <= want_electron_temp;
        end
        mstep_reg <= mstep_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        cnt_reg   <= cnt_next;
        ir_reg    <= ir_next;
        iz_reg    <= iz_next;
        ip_reg    <= ip_next;
        dr_reg    <= dr_next;
        dz_reg    <= dz_next;
        dp_reg    <= dp_next;
        t_reg     <= t_next;
        flat_reg  <= flat_next;
    end

    // Result select: default mode overrides the stored temperatures.
    always_comb
    begin
        if (mode_reg)
            temp_sel = want_reg ? wind_hot : {3'b000, wind_reg};
        else if (flat_inside)
            temp_sel = want_reg ? rd_electron : rd_radiation;
        else
            temp_sel = '0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            density_reg <= flat_inside ? rd_density : 64'd0;
            temp_reg    <= temp_sel;
            cidx_reg    <= flat_reg[11:0];
            ins_reg     <= flat_inside;
        end
    end

    assign result_valid = rv_reg;
    assign density      = density_reg;
    assign temperature  = temp_reg;
    assign cell_index   = cidx_reg;
    assign in_store     = ins_reg;

    cgcl_root u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .sum_sq   (acc_next),
        .wind     (wind_reg),
        .done     (root_done),
        .radius   (radius),
        .wind_hot (wind_hot)
    );

    cgcl_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_done),
        .x_mag (xm_reg),
        .y_mag (ym_reg),
        .x_neg (xn_reg),
        .y_neg (yn_reg),
        .done  (cordic_done),
        .phi   (phi)
    );

    cgcl_store u_store (
        .clk        (clk),
        .we         (cell_we),
        .waddr      (CELL_AW'(entry_index)),
        .wdensity   (density_word),
        .welectron  (electron_temp_in),
        .wradiation (radiation_temp_in),
        .raddr      (flat_reg[CELL_AW-1:0]),
        .rdensity   (rd_density),
        .relectron  (rd_electron),
        .rradiation (rd_radiation)
    );

endmodule

[design/cgcl_checker.sv]
`include "cylindrical_grid_cell_lookup_defines.svh"

module cgcl_checker
    import cgcl_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        query_valid,
    input logic        query_stall,
    input logic [2:0]  cmd,
    input logic        result_valid,
    input logic        result_stall,
    input logic [63:0] density,
    input logic [31:0] temperature,
    input logic        in_store
);

    `CGCL_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(density) && $stable(temperature), "stalled result changed")
    `CGCL_ASSERT_NEXT(a_query_busy, query_valid && !query_stall && cmd == CMD_QUERY, query_stall && !$rose(result_valid), "query did not hold off the channel")
    `CGCL_ASSERT_NEXT(a_write_silent, query_valid && !query_stall && cmd != CMD_QUERY && !result_valid, !result_valid, "write item produced a result")
    `CGCL_ASSERT_SAME(a_outside_zero, result_valid && !in_store, density == 64'd0, "density nonzero outside the store")

endmodule

bind cylindrical_grid_cell_lookup cgcl_checker u_cgcl_checker (.*);

[bench/cylindrical_grid_cell_lookup_tb.sv]
`default_nettype none

module cylindrical_grid_cell_lookup_tb;
    import cgcl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Commands the block drops without a result.
    localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
    localparam logic [2:0] CMD_SPARE_MID = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

    localparam int          ITEM_TARGET = 1350;
    localparam int          PHASES      = 8;
    localparam int          HOLD_CYCLES = 1500;
    localparam logic [28:0] WIND_MAX    = 29'd390451572;

    // arctan(2^-s) in Q3.29; later steps add nothing.
    localparam longint ATAN_Q29 [0:29] = '{
        421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
        8387925, 4194219, 2097141, 1048575, 524288, 262144,
        131072, 65536, 32768, 16384, 8192, 4096,
        2048, 1024, 512, 256, 128, 64,
        32, 16, 8, 4, 2, 1
    };

    typedef struct packed {
        logic [2:0]  op;
        logic [11:0] idx;
        logic [47:0] x;
        logic [47:0] y;
        logic [47:0] z;
        logic        want;
        logic [47:0] edge_val;
        logic [63:0] dens;
        logic [31:0] te;
        logic [31:0] tr;
    } lookup_item_t;

    typedef struct packed {
        logic [63:0] density;
        logic [31:0] temperature;
        logic [11:0] cell_index;
        logic        in_store;
    } cell_result_t;

    typedef struct packed {
        lookup_item_t item;
        logic         typed;
        cell_result_t result;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        query_valid;
    logic        query_stall;
    logic [2:0]  cmd;
    logic [11:0] entry_index;
    logic [47:0] pos_x;
    logic [47:0] pos_y;
    logic [47:0] pos_z;
    logic        want_electron_temp;
    logic [47:0] edge_value;
    logic [63:0] density_word;
    logic [31:0] electron_temp_in;
    logic [31:0] radiation_temp_in;
    logic        result_valid;
    logic        result_stall;
    logic [63:0] density;
    logic [31:0] temperature;
    logic [11:0] cell_index;
    logic        in_store;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [28:0] cfg_data;

    cylindrical_grid_cell_lookup dut (.*);

    // Shadow copy of the grid: boundary tables, cell store and registers.
    longint      radial_tab [AXIS_DEPTH];
    longint      height_tab [AXIS_DEPTH];
    logic [31:0] azim_tab [AXIS_DEPTH];
    logic [63:0] dens_store [CELL_DEPTH];
    logic [31:0] te_store [CELL_DEPTH];
    logic [31:0] tr_store [CELL_DEPTH];
    bit          written [CELL_DEPTH];
    logic [6:0]  nr_reg = 7'd1;
    logic [6:0]  nz_reg = 7'd1;
    logic [6:0]  np_reg = 7'd1;
    logic        mode_reg = 1'b1;
    logic [28:0] wind_reg = 29'd0;

    // Lookups still owed by the block, oldest first.
    cell_result_t owed_lookups [$];
    cell_result_t head;

    int  errors;
    int  items;
    int  lookups_sent;
    int  lookups_seen;
    int  grid_settings;
    int  span_shift = 10;
    bit  no_gaps;
    bit  hold_req;

    always #10 clk = ~clk;

    // Zero acts as one, anything past the table depth as the depth.
    function automatic int unsigned eff_count(input logic [6:0] n);
        if (n == 7'd0)
            return 1;
        return (int'(n) > AXIS_DEPTH) ? AXIS_DEPTH : int'(n);
    endfunction

    // Vectoring CORDIC on the magnitudes, then fold back into the quadrant.
    function automatic logic [31:0] azimuth_q29(input longint x, input longint y);
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned m;
        longint          cx;
        longint          cy;
        longint          ang;
        longint          dx;
        longint          dy;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        if (ax == 0 && ay == 0)
            return 32'd0;
        m = (ax > ay) ? ax : ay;
        while (m < (64'd1 << 46))
        begin
            ax <<= 1;
            ay <<= 1;
            m <<= 1;
        end
        cx = longint'(ax);
        cy = longint'(ay);
        ang = 0;
        for (int s = 0; s < CORDIC_STEPS; s++)
        begin
            dx = cy >>> s;
            dy = cx >>> s;
            if (cy >= 0)
            begin
                cx += dx;
                cy -= dy;
                ang += (s < 30) ? ATAN_Q29[s] : 0;
            end
            else
            begin
                cx -= dx;
                cy += dy;
                ang -= (s < 30) ? ATAN_Q29[s] : 0;
            end
        end
        if (ang < 0)
            ang = 0;
        if (ang > longint'(PHI_HALF_PI))
            ang = longint'(PHI_HALF_PI);
        if (x < 0)
            ang = (y < 0) ? longint'(PHI_PI) + ang : longint'(PHI_PI) - ang;
        else if (y < 0)
            ang = longint'(PHI_TWO_PI) - ang;
        if (ang >= longint'(PHI_TWO_PI))
            ang -= longint'(PHI_TWO_PI);
        return ang[31:0];
    endfunction

    // Find the cell of a position and what the block returns for it.
    function automatic cell_result_t locate(input lookup_item_t it);
        cell_result_t    r;
        longint          x;
        longint          y;
        longint          z;
        longint unsigned ax;
        longint unsigned ay;
        logic [127:0]    r2;
        logic [127:0]    e2;
        logic [31:0]     phi;
        int unsigned     nr;
        int unsigned     nz;
        int unsigned     np;
        int unsigned     i;
        int unsigned     j;
        int unsigned     k;
        int unsigned     flat;
        longint unsigned temp;
        x = longint'($signed(it.x));
        y = longint'($signed(it.y));
        z = longint'($signed(it.z));
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        r2 = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
        phi = azimuth_q29(x, y);
        nr = eff_count(nr_reg);
        nz = eff_count(nz_reg);
        np = eff_count(np_reg);
        i = 0;
        while (i + 1 < nr)
        begin
            if (radial_tab[i + 1] > 0)
            begin
                e2 = 128'(radial_tab[i + 1]) * 128'(radial_tab[i + 1]);
                if (e2 > r2)
                    break;
            end
            i++;
        end
        j = 0;
        while (j + 1 < nz && z >= height_tab[j + 1])
            j++;
        k = 0;
        while (k + 1 < np && phi >= azim_tab[k + 1])
            k++;
        flat = (i * nz + j) * np + k;
        r = '0;
        r.cell_index = flat[11:0];
        r.in_store = (flat < CELL_DEPTH);
        temp = 0;
        if (r.in_store)
        begin
            r.density = dens_store[flat];
            temp = it.want ? te_store[flat] : tr_store[flat];
        end
        if (mode_reg)
            temp = it.want ? (64'(wind_reg) * 11 + 5) / 10 : 64'(wind_reg);
        r.temperature = temp[31:0];
        return r;
    endfunction

    function automatic void store_item(input lookup_item_t it);
        case (it.op)
            CMD_RADIAL:  if (it.idx < AXIS_DEPTH) radial_tab[it.idx] = longint'($signed(it.edge_val));
            CMD_HEIGHT:  if (it.idx < AXIS_DEPTH) height_tab[it.idx] = longint'($signed(it.edge_val));
            CMD_AZIMUTH: if (it.idx < AXIS_DEPTH) azim_tab[it.idx] = it.edge_val[31:0];
            CMD_CELL:
            begin
                dens_store[it.idx] = it.dens;
                te_store[it.idx] = it.te;
                tr_store[it.idx] = it.tr;
                written[it.idx] = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic lookup_item_t write_of(input logic [2:0] op, input logic [11:0] idx,
                                              input logic [47:0] val);
        lookup_item_t it;
        it = '0;
        it.op = op;
        it.idx = idx;
        it.edge_val = val;
        it.dens = {$urandom, $urandom};
        it.te = $urandom;
        it.tr = $urandom;
        return it;
    endfunction

    function automatic directed_row_t row(input logic [2:0] op, input logic [11:0] idx,
                                          input logic [47:0] x, input logic [47:0] y,
                                          input logic [47:0] z, input logic want,
                                          input logic [47:0] val, input logic [63:0] dens,
                                          input logic [31:0] te, input logic [31:0] tr,
                                          input logic typed, input logic [63:0] r_dens);
        directed_row_t d;
        d.item = '{op, idx, x, y, z, want, val, dens, te, tr};
        d.typed = typed;
        d.result = '{r_dens, 32'd0, 12'd0, 1'b1};
        return d;
    endfunction

    // Mostly within the grid span, now and then anywhere or on an axis.
    function automatic logic [47:0] coord();
        logic [47:0]     raw;
        longint unsigned span;
        raw = 48'({$urandom, $urandom});
        case ($urandom_range(0, 15))
            0:       return 48'd0;
            1, 2:    return raw;
            default:
            begin
                span = 64'd1 << (span_shift + 1);
                return 48'(longint'({16'd0, raw} % (span + 1)) - (longint'(1) << span_shift));
            end
        endcase
    endfunction

    // Offer one item and wait for it to be taken; valid stays high on return unless a random gap drops it.
    task automatic offer(input lookup_item_t it, input bit typed, input cell_result_t fixed);
        query_valid        <= 1'b1;
        cmd                <= it.op;
        entry_index        <= it.idx;
        pos_x              <= it.x;
        pos_y              <= it.y;
        pos_z              <= it.z;
        want_electron_temp <= it.want;
        edge_value         <= it.edge_val;
        density_word       <= it.dens;
        electron_temp_in   <= it.te;
        radiation_temp_in  <= it.tr;
        @(posedge clk);
        while (query_stall)
            @(posedge clk);
        // Taken at this edge: predict or update the shadow grid.
        if (it.op == CMD_QUERY)
        begin
            owed_lookups.push_back(typed ? fixed : locate(it));
            lookups_sent++;
        end
        else
            store_item(it);
        if (it.op <= CMD_CELL && !(it.op != CMD_CELL && it.op != CMD_QUERY && it.idx >= AXIS_DEPTH))
            items++;
        if (!no_gaps && $urandom_range(0, 3) == 0)
        begin
            query_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // Drop valid and let the block go quiet before touching registers.
    task automatic settle();
        query_valid <= 1'b0;
        while (owed_lookups.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [28:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_RADIAL_CELLS:  nr_reg = val[6:0];
            REG_HEIGHT_CELLS:  nz_reg = val[6:0];
            REG_AZIMUTH_CELLS: np_reg = val[6:0];
            REG_DEFAULT_MODE:  mode_reg = val[0];
            REG_WIND_TEMP:     wind_reg = val;
            default: ;
        endcase
    endtask

    // New grid: registers, then sorted boundaries with jitter for each axis.
    task automatic program_grid(input logic [6:0] nr, input logic [6:0] nz, input logic [6:0] np,
                                input logic mode, input logic [28:0] wind);
        longint step;
        settle();
        write_reg(REG_RADIAL_CELLS, 29'(nr));
        write_reg(REG_HEIGHT_CELLS, 29'(nz));
        write_reg(REG_AZIMUTH_CELLS, 29'(np));
        write_reg(REG_DEFAULT_MODE, 29'(mode));
        write_reg(REG_WIND_TEMP, wind);
        cfg_write <= 1'b0;
        span_shift = $urandom_range(8, 44);
        step = (longint'(1) << span_shift) / eff_count(nr);
        for (int a = 1; a < eff_count(nr); a++)
            offer(write_of(CMD_RADIAL, 12'(a),
                           48'(a * step + $urandom_range(0, 3) * (step / 8))), 1'b0, '0);
        step = (longint'(2) << span_shift) / eff_count(nz);
        for (int a = 1; a < eff_count(nz); a++)
            offer(write_of(CMD_HEIGHT, 12'(a),
                           48'(a * step - (longint'(1) << span_shift)
                               + $urandom_range(0, 3) * (step / 8))), 1'b0, '0);
        step = longint'(PHI_TWO_PI) / eff_count(np);
        for (int a = 1; a < eff_count(np); a++)
            offer(write_of(CMD_AZIMUTH, 12'(a),
                           {16'($urandom), 32'(a * step + $urandom_range(0, 3) * (step / 8))}),
                  1'b0, '0);
        grid_settings++;
    endtask

    // Mostly lookups with random content, the rest writes and dropped commands.
    task automatic random_item();
        lookup_item_t it;
        cell_result_t r;
        int unsigned  pick;
        it = write_of(CMD_QUERY, 12'($urandom), 48'({$urandom, $urandom}));
        it.x = coord();
        it.y = coord();
        it.z = coord();
        it.want = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 10)
            it.op = CMD_CELL;
        else if (pick < 19)
        begin
            case ($urandom_range(0, 2))
                0:       it.op = CMD_RADIAL;
                1:       it.op = CMD_HEIGHT;
                default: it.op = CMD_AZIMUTH;
            endcase
            if ($urandom_range(0, 1))
                it.idx = 12'($urandom_range(0, AXIS_DEPTH - 1));
        end
        else if (pick < 22)
        begin
            case ($urandom_range(0, 2))
                0:       it.op = CMD_SPARE_LO;
                1:       it.op = CMD_SPARE_MID;
                default: it.op = CMD_SPARE_HI;
            endcase
        end
        if (it.op == CMD_QUERY)
        begin
            // Fill the target cell first if it has never been loaded.
            r = locate(it);
            if (r.in_store && !written[r.cell_index])
                offer(write_of(CMD_CELL, r.cell_index, 48'd0), 1'b0, '0);
        end
        offer(it, 1'b0, '0);
    endtask

    task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
            errors++;
        end
    endtask

    // Compare every taken result with the oldest owed lookup.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            lookups_seen++;
            if (owed_lookups.size() == 0)
            begin
                $display("%0t: result with none owed, got density %h temperature %h",
                         $realtime, density, temperature);
                errors++;
            end
            else
            begin
                head = owed_lookups.pop_front();
                report("density", head.density, density);
                report("temperature", 64'(head.temperature), 64'(temperature));
                report("cell_index", 64'(head.cell_index), 64'(cell_index));
                report("in_store", 64'(head.in_store), 64'(in_store));
            end
        end
    end

    // Result side: random stall bursts, one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                result_stall <= 1'b0;
            end
            else if (!no_gaps && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                result_stall <= 1'b0;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // Backstop against a hung block.
    initial
    begin
        #40ms;
        $display("[cylindrical_grid_cell_lookup] ERROR");
        $finish;
    end

    initial
    begin
        directed_row_t rows [16];
        logic [6:0]    nr;
        logic [6:0]    nz;
        logic [6:0]    np;
        logic          mode;
        logic [28:0]   wind;
        int            phase_end;

        clk = 1'b0;
        rst_n = 1'b0;
        query_valid = 1'b0;
        cmd = CMD_QUERY;
        entry_index = '0;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        want_electron_temp = 1'b0;
        edge_value = '0;
        density_word = '0;
        electron_temp_in = '0;
        radiation_temp_in = '0;
        result_stall = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_RADIAL_CELLS;
        cfg_data = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset grid is a single cell, default mode with zero wind temperature,
        // so every lookup lands on cell 0 with temperature 0.
        rows[0]  = row(CMD_CELL, 12'd0, '0, '0, '0, 1'b0, '0, '1, '1, '0, 1'b0, '0);
        rows[1]  = row(CMD_QUERY, '0, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
                       48'h8000_0000_0000, 1'b1, '0, '0, '0, '0, 1'b1, '1);
        rows[2]  = row(CMD_QUERY, '0, 48'h8000_0000_0000, 48'h8000_0000_0000,
                       48'h7FFF_FFFF_FFFF, 1'b0, '0, '0, '0, '0, 1'b1, '1);
        // origin
        rows[3]  = row(CMD_QUERY, '0, '0, '0, '0, 1'b1, '0, '0, '0, '0, 1'b1, '1);
        // negative x axis and one step down the negative y axis
        rows[4]  = row(CMD_QUERY, '0, -48'sd256, '0, '0, 1'b0, '0, '0, '0, '0, 1'b1, '1);
        rows[5]  = row(CMD_QUERY, '0, '0, '1, '1, 1'b1, '0, '0, '0, '0, 1'b1, '1);
        // unknown commands are dropped
        rows[6]  = row(CMD_SPARE_LO, '1, '1, '1, '1, 1'b1, '1, '1, '1, '1, 1'b0, '0);
        rows[7]  = row(CMD_SPARE_MID, '0, '0, '0, '0, 1'b0, '0, '0, '0, '0, 1'b0, '0);
        rows[8]  = row(CMD_SPARE_HI, 12'd5, '0, '0, '0, 1'b1, '1, '0, '1, '0, 1'b0, '0);
        // boundary write beyond the table is dropped, then table and cell writes
        rows[9]  = row(CMD_RADIAL, 12'd4095, '0, '0, '0, 1'b0, 48'h7FFF_FFFF_FFFF,
                       '0, '0, '0, 1'b0, '0);
        rows[10] = row(CMD_RADIAL, 12'd63, '0, '0, '0, 1'b0, 48'h8000_0000_0000,
                       '0, '0, '0, 1'b0, '0);
        rows[11] = row(CMD_HEIGHT, 12'd0, '0, '0, '0, 1'b0, 48'h7FFF_FFFF_FFFF,
                       '0, '0, '0, 1'b0, '0);
        rows[12] = row(CMD_AZIMUTH, 12'd1, '0, '0, '0, 1'b0, '1, '0, '0, '0, 1'b0, '0);
        rows[13] = row(CMD_CELL, 12'd4095, '0, '0, '0, 1'b0, '0, '0, '0, '1, 1'b0, '0);
        rows[14] = row(CMD_CELL, 12'd0, '0, '0, '0, 1'b0, '0, 64'h0123_4567_89AB_CDEF,
                       32'd1, 32'd2, 1'b0, '0);
        rows[15] = row(CMD_QUERY, '0, 48'd1, 48'd1, '0, 1'b0, '0, '0, '0, '0, 1'b1,
                       64'h0123_4567_89AB_CDEF);
        foreach (rows[r])
            offer(rows[r].item, rows[r].typed, rows[r].result);

        for (int p = 0; p < PHASES; p++)
        begin
            wind = 29'($urandom_range(0, WIND_MAX));
            mode = 1'($urandom);
            case (p)
                0:       begin nr = 7'd64; nz = 7'd64; np = 7'd64; mode = 1'b0; end
                1:       begin nr = 7'd1; nz = 7'd1; np = 7'd1; mode = 1'b0; wind = '0; end
                2:       begin nr = 7'd4; nz = 7'd8; np = 7'd16; mode = 1'b1; wind = WIND_MAX; end
                3:       begin nr = 7'd0; nz = 7'd127; np = 7'd3; mode = 1'b0; end
                default:
                begin
                    nr = 7'($urandom_range(2, 10));
                    nz = 7'($urandom_range(2, 10));
                    np = 7'($urandom_range(2, 10));
                end
            endcase
            program_grid(nr, nz, np, mode, wind);
            // Hold the results back for a long while so the block backs up.
            if (p == 0)
                hold_req = 1'b1;
            // Run the tail of the stimulus without idle cycles.
            if (p == PHASES - 1)
                no_gaps = 1'b1;
            phase_end = (p == PHASES - 1) ? ITEM_TARGET
                                          : items + (ITEM_TARGET - items) / (PHASES - p);
            while (items < phase_end)
                random_item();
        end

        query_valid <= 1'b0;
        while (owed_lookups.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (owed_lookups.size() != 0)
        begin
            $display("%0t: %0d lookups never returned", $realtime, owed_lookups.size());
            errors++;
        end

        $display("Ran %0d items over %0d grid settings; %0d of %0d lookups came back.",
                 items, grid_settings + 1, lookups_seen, lookups_sent);
        $display("Mismatches: %0d", errors);
        if (errors == 0)
            $display("[cylindrical_grid_cell_lookup] OK");
        else
            $display("[cylindrical_grid_cell_lookup] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
